// ----- rtl/mcsc_pkg.sv -----
// ----------------------------------------------------------------------------
// mcsc_pkg
// Shared sizes, codes and the command bundle of the stick cutting cost block.
// ----------------------------------------------------------------------------
package mcsc_pkg;

	// Capacity and position width
	localparam int MAX_CUTS = 64;
	localparam int POS_BITS = 16;

	// Points: left boundary, the cuts, right boundary
	localparam int NPTS  = MAX_CUTS + 2;
	localparam int IDX_W = $clog2(NPTS);
	localparam int CNT_W = $clog2(MAX_CUTS + 1);

	// Cost table, row-major NPTS x NPTS
	localparam int CELLS = NPTS * NPTS;
	localparam int CA_W  = $clog2(CELLS);

	// Field and arithmetic widths
	localparam int CFG_W   = 16;
	localparam int CUT_W   = 16;
	localparam int ENTRY_W = 23;
	localparam int OUT_W   = 22;
	localparam int SUM_W   = ENTRY_W + 1;
	localparam int TOT_W   = ((SUM_W > POS_BITS) ? SUM_W : POS_BITS) + 1;

	// Item kinds
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// Point write data sources
	localparam logic [1:0] PT_SRC_CUT   = 2'd0;
	localparam logic [1:0] PT_SRC_ZERO  = 2'd1;
	localparam logic [1:0] PT_SRC_STICK = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       pt_we;
		logic [1:0] pt_wsel;
		idx_t       pt_waddr;
		logic       cost_we;
		logic       acc_en;
		logic       acc_first;
		logic       zero_a;
		logic       zero_b;
		idx_t       idx_i;
		idx_t       idx_k;
		idx_t       idx_j;
		logic       res_load;
		logic       res_empty;
		logic       res_ovf;
	} cmd_t;

endpackage

// ----- rtl/mcsc_in_if.sv -----
// ----------------------------------------------------------------------------
// mcsc_in_if
// Input channel: cut loads and finish requests.
// ----------------------------------------------------------------------------
interface mcsc_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] cut_position;

	modport source (output valid, output kind, output cut_position, input ready);
	modport sink   (input valid, input kind, input cut_position, output ready);
endinterface

// ----- rtl/mcsc_out_if.sv -----
// ----------------------------------------------------------------------------
// mcsc_out_if
// Result channel: minimum cutting cost and overflow flag.
// ----------------------------------------------------------------------------
interface mcsc_out_if;
	logic        valid;
	logic        ready;
	logic [21:0] min_cost;
	logic        overflow;

	modport source (output valid, output min_cost, output overflow, input ready);
	modport sink   (input valid, input min_cost, input overflow, output ready);
endinterface

// ----- rtl/min_cost_stick_cutting_dp.sv -----
// ----------------------------------------------------------------------------
// min_cost_stick_cutting_dp
// Minimum-cost stick cutting by interval dynamic programming over loaded cuts.
//
//   channel  dir   handshake      payload
//   item     in    valid/ready    kind, cut_position
//   result   out   valid/ready    min_cost, overflow
//   cfg      in    cfg_we         cfg_wdata (stick_length)
//
// Cut loads are accepted back to back.
// A finish writes the left and right boundary points, then for each interval
// (i,j) of the table runs the split loop, reading two table entries through
// the cost RAM's two read ports, drains, writes the entry; then it hands off.
// Input is held off from finish until the result sits in the output slot;
// the slot frees when taken. Asynchronous reset; no clearing pass.
// ----------------------------------------------------------------------------
module min_cost_stick_cutting_dp
	import mcsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	mcsc_in_if.sink           item,
	mcsc_out_if.source        result
);

	cmd_t cmd;

	mcsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_kind   (item.kind),
		.in_ready  (item.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	mcsc_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cut_position (item.cut_position),
		.cmd          (cmd),
		.min_cost     (result.min_cost),
		.overflow     (result.overflow)
	);

	// A table write needs the drain cycle after the last split read
	a_drain_before_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_en |=> !cmd.cost_we)
		else $error("cost write right after split read");

	// Table write and accumulate never overlap
	a_write_not_acc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cost_we |-> !cmd.acc_en)
		else $error("cost write during accumulate");

	// Result only loads into a free slot
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!result.valid || result.ready))
		else $error("result overwrote pending transaction");

	// A new result appears only after a load command
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.res_load))
		else $error("result valid without load");

endmodule

// ----- rtl/mcsc_ram.sv -----
// ----------------------------------------------------------------------------
// mcsc_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mcsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered reads
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ----- rtl/mcsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcsc_ctrl
// Sequencer: takes cut loads, then walks interval length, start point and
// split point of the cost table and hands the result to the output slot.
// ----------------------------------------------------------------------------
module mcsc_ctrl
	import mcsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_kind,
	output logic in_ready,
	input  logic out_ready,
	output logic out_valid,
	output cmd_t cmd
);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_P0    = 3'd1;
	localparam logic [2:0] S_PL    = 3'd2;
	localparam logic [2:0] S_IJ    = 3'd3;
	localparam logic [2:0] S_K     = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_WR    = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cut_count_q;
	logic             ovf_q;
	idx_t             len_q;
	idx_t             i_q;
	idx_t             j_q;
	idx_t             k_q;
	logic             out_valid_q;

	idx_t last;
	logic accept;
	logic room;
	logic slot_free;

	assign last      = IDX_W'(cut_count_q) + IDX_W'(1);
	assign in_ready  = (state_q == S_LOAD);
	assign accept    = in_valid && in_ready;
	assign room      = (cut_count_q < CNT_W'(MAX_CUTS));
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Command decode
	always_comb begin
		cmd           = '0;
		cmd.idx_i     = i_q;
		cmd.idx_k     = k_q;
		cmd.idx_j     = j_q;
		cmd.pt_wsel   = PT_SRC_CUT;
		cmd.pt_waddr  = IDX_W'(cut_count_q) + IDX_W'(1);
		cmd.res_empty = (last == IDX_W'(1));
		cmd.res_ovf   = ovf_q;
		case (state_q)
			S_LOAD: begin
				cmd.pt_we = accept && (in_kind == KIND_LOAD) && room;
			end
			S_P0: begin
				cmd.pt_we    = 1'b1;
				cmd.pt_wsel  = PT_SRC_ZERO;
				cmd.pt_waddr = '0;
			end
			S_PL: begin
				cmd.pt_we    = 1'b1;
				cmd.pt_wsel  = PT_SRC_STICK;
				cmd.pt_waddr = last;
			end
			S_K: begin
				cmd.acc_en    = 1'b1;
				cmd.acc_first = (k_q == i_q + IDX_W'(1));
				cmd.zero_a    = (k_q == i_q + IDX_W'(1));
				cmd.zero_b    = (k_q + IDX_W'(1) == j_q);
			end
			S_WR: begin
				cmd.cost_we = 1'b1;
			end
			S_FIN: begin
				cmd.res_load = slot_free;
			end
			default: begin
				cmd.pt_we = 1'b0;
			end
		endcase
	end

	// State and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cut_count_q <= '0;
			ovf_q       <= 1'b0;
			len_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (in_kind == KIND_FINISH) begin
							state_q <= S_P0;
						end else if (room) begin
							cut_count_q <= cut_count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				S_P0: begin
					state_q <= S_PL;
				end
				S_PL: begin
					if (last == IDX_W'(1)) begin
						state_q <= S_FIN;
					end else begin
						len_q   <= IDX_W'(2);
						i_q     <= '0;
						j_q     <= IDX_W'(2);
						state_q <= S_IJ;
					end
				end
				S_IJ: begin
					k_q     <= i_q + IDX_W'(1);
					state_q <= S_K;
				end
				S_K: begin
					if (k_q + IDX_W'(1) == j_q) begin
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (j_q != last) begin
						i_q     <= i_q + IDX_W'(1);
						j_q     <= j_q + IDX_W'(1);
						state_q <= S_IJ;
					end else if (len_q == last) begin
						state_q <= S_FIN;
					end else begin
						len_q   <= len_q + IDX_W'(1);
						i_q     <= '0;
						j_q     <= len_q + IDX_W'(1);
						state_q <= S_IJ;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						cut_count_q <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Output slot valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/mcsc_dpath.sv -----
// ----------------------------------------------------------------------------
// mcsc_dpath
// Datapath: stick length register, point store, cost table, min-accumulate
// over split points, span add with saturation and the result register.
// ----------------------------------------------------------------------------
module mcsc_dpath
	import mcsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic [CUT_W-1:0]   cut_position,
	input  cmd_t               cmd,
	output logic [OUT_W-1:0]   min_cost,
	output logic               overflow
);

	localparam logic [ENTRY_W-1:0] ENTRY_MAX = {ENTRY_W{1'b1}};
	localparam logic [OUT_W-1:0]   OUT_MAX   = {OUT_W{1'b1}};

	// Row-major cell address, constant row stride
	function automatic logic [CA_W-1:0] cell_addr(input idx_t row, input idx_t col);
		cell_addr = CA_W'(row) * CA_W'(NPTS) + CA_W'(col);
	endfunction

	logic [CFG_W-1:0]    stick_q;
	logic [POS_BITS-1:0] pt_wdata;
	logic [POS_BITS-1:0] pt_lo;
	logic [POS_BITS-1:0] pt_hi;
	logic [POS_BITS-1:0] span;
	logic [ENTRY_W-1:0]  rd_a;
	logic [ENTRY_W-1:0]  rd_b;
	logic [ENTRY_W-1:0]  term_a;
	logic [ENTRY_W-1:0]  term_b;
	logic [SUM_W-1:0]    pair_sum;
	logic [SUM_W-1:0]    best_q;
	logic [TOT_W-1:0]    total;
	logic [ENTRY_W-1:0]  entry;
	logic [ENTRY_W-1:0]  last_entry_q;
	logic                acc_s1;
	logic                first_s1;
	logic                za_s1;
	logic                zb_s1;
	logic [OUT_W-1:0]    min_cost_q;
	logic                overflow_q;

	// Stick length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_q <= CFG_W'(1);
		end else if (cfg_we) begin
			stick_q <= cfg_wdata;
		end
	end

	// Point write data
	always_comb begin
		case (cmd.pt_wsel)
			PT_SRC_CUT:   pt_wdata = POS_BITS'(cut_position);
			PT_SRC_STICK: pt_wdata = POS_BITS'(stick_q);
			default:      pt_wdata = '0;
		endcase
	end

	mcsc_ram #(.WIDTH(POS_BITS), .DEPTH(NPTS)) u_points (
		.clk     (clk),
		.we      (cmd.pt_we),
		.waddr   (cmd.pt_waddr),
		.wdata   (pt_wdata),
		.raddr_a (cmd.idx_i),
		.raddr_b (cmd.idx_j),
		.rdata_a (pt_lo),
		.rdata_b (pt_hi)
	);

	mcsc_ram #(.WIDTH(ENTRY_W), .DEPTH(CELLS)) u_costs (
		.clk     (clk),
		.we      (cmd.cost_we),
		.waddr   (cell_addr(cmd.idx_i, cmd.idx_j)),
		.wdata   (entry),
		.raddr_a (cell_addr(cmd.idx_i, cmd.idx_k)),
		.raddr_b (cell_addr(cmd.idx_k, cmd.idx_j)),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Flags travel alongside the table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
		end else begin
			acc_s1 <= cmd.acc_en;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.acc_first;
		za_s1    <= cmd.zero_a;
		zb_s1    <= cmd.zero_b;
	end

	// Adjacent-point intervals cost nothing
	assign term_a   = za_s1 ? '0 : rd_a;
	assign term_b   = zb_s1 ? '0 : rd_b;
	assign pair_sum = SUM_W'(term_a) + SUM_W'(term_b);

	// Running minimum over split points
	always_ff @(posedge clk) begin
		if (acc_s1 && (first_s1 || pair_sum < best_q)) begin
			best_q <= pair_sum;
		end
	end

	// Span of the interval, zero when the points run backwards
	assign span  = (pt_hi >= pt_lo) ? pt_hi - pt_lo : '0;
	assign total = TOT_W'(best_q) + TOT_W'(span);
	assign entry = (total > TOT_W'(ENTRY_MAX)) ? ENTRY_MAX : total[ENTRY_W-1:0];

	// The final write of a finish is the whole-stick entry
	always_ff @(posedge clk) begin
		if (cmd.cost_we) begin
			last_entry_q <= entry;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			if (cmd.res_empty) begin
				min_cost_q <= '0;
			end else if (last_entry_q > ENTRY_W'(OUT_MAX)) begin
				min_cost_q <= OUT_MAX;
			end else begin
				min_cost_q <= last_entry_q[OUT_W-1:0];
			end
			overflow_q <= cmd.res_ovf;
		end
	end

	assign min_cost = min_cost_q;
	assign overflow = overflow_q;

endmodule
